[rtl/pid2dof_pkg.sv]
// pid2dof_pkg: shared types and constants for the two-degree-of-freedom pid controller
`timescale 1ns / 1ps
`default_nettype none

package pid2dof_pkg;

   // fixed field widths
   localparam int DT_W        = 24;
   localparam int GAIN_W      = 24;
   localparam int LIMIT_W     = 31;
   localparam int RATE_W      = 33;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   // signed accumulator for drive and integrator sums
   localparam int ACC_W = 64;

   // term magnitudes saturate at 2^60
   localparam int TERM_SAT_BIT = 60;
   localparam int TERM_W       = TERM_SAT_BIT + 1;
   localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, {TERM_SAT_BIT{1'b0}}};

   // digit-serial multiplier geometry
   localparam int DIGIT_W     = 4;
   localparam int RES_DIGITS  = TERM_SAT_BIT / DIGIT_W;
   localparam int RES_BITS    = RES_DIGITS * DIGIT_W;
   localparam int MUL_A_W     = ((TERM_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
   localparam int MUL_B_W     = RATE_W;
   localparam int MUL_PART_W  = MUL_B_W + DIGIT_W;
   localparam int MUL_DIGITS  = (TERM_W + MUL_B_W + DIGIT_W - 1) / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(MUL_DIGITS + 1);
   localparam int SKIP_W      = 4;

   // digits dropped by each right shift
   localparam logic [SKIP_W-1:0] SKIP_NONE = SKIP_W'(0);
   localparam logic [SKIP_W-1:0] SKIP_PROP = SKIP_W'(16 / DIGIT_W);
   localparam logic [SKIP_W-1:0] SKIP_RATE = SKIP_W'(24 / DIGIT_W);
   localparam logic [SKIP_W-1:0] SKIP_STEP = SKIP_W'(40 / DIGIT_W);

   // reciprocal 2^32 / step_time, one quotient bit a step
   localparam int RECIP_STEPS = RATE_W;
   localparam int RECIP_CNT_W = $clog2(RECIP_STEPS + 1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INT_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEAS_GAIN     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SP_GAIN       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_LIMIT = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RECIP,
      ST_MSTART,
      ST_MWAIT,
      ST_POST,
      ST_CLAMP,
      ST_ADDI,
      ST_SAT
   } state_type;

   typedef enum logic [2:0] {
      OP_PROP,
      OP_SP_GAIN,
      OP_SP_RATE,
      OP_MEAS_GAIN,
      OP_MEAS_RATE,
      OP_INT_GAIN,
      OP_INT_STEP
   } op_type;

   typedef struct packed {
      logic              start;
      logic [SKIP_W-1:0] skip;
   } mul_ctrl_type;

endpackage

`default_nettype wire

[rtl/pid2dof_if.sv]
// pid2dof_if: valid/ready channels for request and response words
`timescale 1ns / 1ps
`default_nettype none

interface pid2dof_req_if #(parameter int VALUE_WIDTH = 32);
   logic                                valid;
   logic                                ready;
   logic [pid2dof_pkg::DT_W-1:0]        step_time;
   logic signed [VALUE_WIDTH-1:0]       setpoint;
   logic signed [VALUE_WIDTH-1:0]       measurement;
   logic                                clear_integral;

   modport source (output valid, step_time, setpoint, measurement, clear_integral,
                   input ready);
   modport sink   (input valid, step_time, setpoint, measurement, clear_integral,
                   output ready);
endinterface

interface pid2dof_rsp_if #(parameter int VALUE_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] drive;
   logic                          integral_clamped;

   modport source (output valid, drive, integral_clamped, input ready);
   modport sink   (input valid, drive, integral_clamped, output ready);
endinterface

`default_nettype wire

[rtl/pid_two_dof_controller.sv]
// pid_two_dof_controller: top level of the fixed-point two-degree-of-freedom pid controller
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake    word
// req_bus   in   valid/ready  step_time, setpoint, measurement, clear_integral
// rsp_bus   out  valid/ready  drive, integral_clamped
// csr_*     in   write only   csr_index selects gain or limit, csr_wdata the value
//
// each word runs a 33-step serial reciprocal of step_time, then seven 24-digit
// multiplier passes one after another; four add a signed term into the drive or
// integrator sum, three keep their product as the next pass's operand.
// reset clears gains, limit, integrator and the stored setpoint and measurement.
// a held result does not stop the next word being taken; the block only waits
// to load its result while the previous one is still unread.

module pid_two_dof_controller #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   pid2dof_req_if.sink                            req_bus,
   pid2dof_rsp_if.source                          rsp_bus,
   input  logic                                   csr_write,
   input  logic [pid2dof_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pid2dof_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int VW     = VALUE_WIDTH;
   localparam int DIFF_W = VALUE_WIDTH + 1;
   localparam int AW     = pid2dof_pkg::ACC_W;
   localparam logic [AW-1:0] VMAX = (AW'(1) << (VALUE_WIDTH - 1)) - AW'(1);
   localparam logic [AW-1:0] VMIN = ~VMAX;

   // configuration
   logic [pid2dof_pkg::GAIN_W-1:0]   prop_gain_ff;
   logic [pid2dof_pkg::GAIN_W-1:0]   int_gain_ff;
   logic [pid2dof_pkg::GAIN_W-1:0]   meas_gain_ff;
   logic [pid2dof_pkg::GAIN_W-1:0]   sp_gain_ff;
   logic [pid2dof_pkg::LIMIT_W-1:0]  limit_ff;
   logic [pid2dof_pkg::LIMIT_W-1:0]  limit_in;

   // sequencer
   pid2dof_pkg::state_type           state_ff, state_in;
   pid2dof_pkg::op_type              op_ff, op_in;

   // step state and working registers
   logic [pid2dof_pkg::DT_W-1:0]     dt_ff, dt_in;
   logic                             clr_ff, clr_in;
   logic [DIFF_W-1:0]                err_ff, err_in;
   logic [DIFF_W-1:0]                dsp_ff, dsp_in;
   logic [DIFF_W-1:0]                dmeas_ff, dmeas_in;
   logic [VW-1:0]                    prev_sp_ff, prev_sp_in;
   logic [VW-1:0]                    prev_meas_ff, prev_meas_in;
   logic [VW-1:0]                    isum_ff, isum_in;
   logic [pid2dof_pkg::TERM_W-1:0]   inner_ff, inner_in;
   logic [AW-1:0]                    drv_ff, drv_in;
   logic [AW-1:0]                    integ_ff, integ_in;
   logic                             clamped_ff, clamped_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                    rsp_drive_ff, rsp_drive_in;
   logic                             rsp_clamped_ff, rsp_clamped_in;

   // datapath wires
   logic                             req_fire;
   logic                             out_free;
   logic                             recip_start;
   logic                             recip_done;
   logic [pid2dof_pkg::RATE_W-1:0]   rate;
   pid2dof_pkg::mul_ctrl_type        mul_ctrl;
   logic                             mul_done;
   logic [pid2dof_pkg::TERM_W-1:0]   term_mag;
   logic [pid2dof_pkg::MUL_A_W-1:0]  mul_a;
   logic [pid2dof_pkg::MUL_B_W-1:0]  mul_b;
   logic [pid2dof_pkg::SKIP_W-1:0]   mul_skip;
   logic [DIFF_W-1:0]                sel_diff;
   logic [DIFF_W-1:0]                diff_mag;
   logic                             use_diff;
   logic                             term_neg;
   logic [AW-1:0]                    term_ext;
   logic [AW-1:0]                    add_l;
   logic [AW-1:0]                    add_r;
   logic [AW-1:0]                    add_sum;
   logic [AW-1:0]                    lim_ext;
   logic [AW-1:0]                    drive_sat;

   // configuration writes; the limit is held already reduced to the value range
   always_comb begin
      if (AW'(csr_wdata[pid2dof_pkg::LIMIT_W-1:0]) > VMAX) begin
         limit_in = VMAX[pid2dof_pkg::LIMIT_W-1:0];
      end else begin
         limit_in = csr_wdata[pid2dof_pkg::LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff <= '0;
         int_gain_ff  <= '0;
         meas_gain_ff <= '0;
         sp_gain_ff   <= '0;
         limit_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            pid2dof_pkg::CSR_PROP_GAIN: begin
               prop_gain_ff <= csr_wdata[pid2dof_pkg::GAIN_W-1:0];
            end
            pid2dof_pkg::CSR_INT_GAIN: begin
               int_gain_ff <= csr_wdata[pid2dof_pkg::GAIN_W-1:0];
            end
            pid2dof_pkg::CSR_MEAS_GAIN: begin
               meas_gain_ff <= csr_wdata[pid2dof_pkg::GAIN_W-1:0];
            end
            pid2dof_pkg::CSR_SP_GAIN: begin
               sp_gain_ff <= csr_wdata[pid2dof_pkg::GAIN_W-1:0];
            end
            pid2dof_pkg::CSR_INTEGRAL_LIMIT: begin
               limit_ff <= limit_in;
            end
            default: begin
            end
         endcase
      end
   end

   // handshake conditions
   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pid2dof_pkg::ST_IDLE: begin
            if (req_fire) state_in = pid2dof_pkg::ST_RECIP;
         end
         pid2dof_pkg::ST_RECIP: begin
            if (recip_done) state_in = pid2dof_pkg::ST_MSTART;
         end
         pid2dof_pkg::ST_MSTART: begin
            state_in = pid2dof_pkg::ST_MWAIT;
         end
         pid2dof_pkg::ST_MWAIT: begin
            if (mul_done) state_in = pid2dof_pkg::ST_POST;
         end
         pid2dof_pkg::ST_POST: begin
            if (op_ff == pid2dof_pkg::OP_INT_STEP) begin
               state_in = pid2dof_pkg::ST_CLAMP;
            end else begin
               state_in = pid2dof_pkg::ST_MSTART;
            end
         end
         pid2dof_pkg::ST_CLAMP: begin
            state_in = pid2dof_pkg::ST_ADDI;
         end
         pid2dof_pkg::ST_ADDI: begin
            state_in = pid2dof_pkg::ST_SAT;
         end
         pid2dof_pkg::ST_SAT: begin
            if (out_free) state_in = pid2dof_pkg::ST_IDLE;
         end
         default: begin
            state_in = pid2dof_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready  = (state_ff == pid2dof_pkg::ST_IDLE);
      recip_start    = (state_ff == pid2dof_pkg::ST_IDLE) && req_bus.valid;
      mul_ctrl.start = (state_ff == pid2dof_pkg::ST_MSTART);
      mul_ctrl.skip  = mul_skip;
   end

   // operand choice for each multiplier pass
   always_comb begin
      sel_diff = err_ff;
      use_diff = 1'b1;
      mul_b    = pid2dof_pkg::MUL_B_W'(prop_gain_ff);
      mul_skip = pid2dof_pkg::SKIP_PROP;
      term_neg = err_ff[DIFF_W-1];
      case (op_ff)
         pid2dof_pkg::OP_PROP: begin
            sel_diff = err_ff;
            mul_b    = pid2dof_pkg::MUL_B_W'(prop_gain_ff);
            mul_skip = pid2dof_pkg::SKIP_PROP;
            term_neg = err_ff[DIFF_W-1];
         end
         pid2dof_pkg::OP_SP_GAIN: begin
            sel_diff = dsp_ff;
            mul_b    = pid2dof_pkg::MUL_B_W'(sp_gain_ff);
            mul_skip = pid2dof_pkg::SKIP_NONE;
         end
         pid2dof_pkg::OP_SP_RATE: begin
            use_diff = 1'b0;
            mul_b    = rate;
            mul_skip = pid2dof_pkg::SKIP_RATE;
            term_neg = dsp_ff[DIFF_W-1];
         end
         pid2dof_pkg::OP_MEAS_GAIN: begin
            sel_diff = dmeas_ff;
            mul_b    = pid2dof_pkg::MUL_B_W'(meas_gain_ff);
            mul_skip = pid2dof_pkg::SKIP_NONE;
         end
         pid2dof_pkg::OP_MEAS_RATE: begin
            // measurement change enters with the opposite sign
            use_diff = 1'b0;
            mul_b    = rate;
            mul_skip = pid2dof_pkg::SKIP_RATE;
            term_neg = !dmeas_ff[DIFF_W-1];
         end
         pid2dof_pkg::OP_INT_GAIN: begin
            sel_diff = err_ff;
            mul_b    = pid2dof_pkg::MUL_B_W'(int_gain_ff);
            mul_skip = pid2dof_pkg::SKIP_NONE;
         end
         pid2dof_pkg::OP_INT_STEP: begin
            use_diff = 1'b0;
            mul_b    = pid2dof_pkg::MUL_B_W'(dt_ff);
            mul_skip = pid2dof_pkg::SKIP_STEP;
            term_neg = err_ff[DIFF_W-1];
         end
         default: begin
         end
      endcase
      diff_mag = sel_diff[DIFF_W-1] ? (~sel_diff + DIFF_W'(1)) : sel_diff;
      mul_a    = use_diff ? pid2dof_pkg::MUL_A_W'(diff_mag)
                          : pid2dof_pkg::MUL_A_W'(inner_ff);
   end

   // shared accumulator adder: signed terms, integrator base, then integrator into drive
   always_comb begin
      term_ext = AW'(term_mag);
      if ((state_ff == pid2dof_pkg::ST_POST) && (op_ff == pid2dof_pkg::OP_INT_STEP)) begin
         add_l = clr_ff ? '0 : {{(AW - VW){isum_ff[VW-1]}}, isum_ff};
      end else begin
         add_l = drv_ff;
      end
      if (state_ff == pid2dof_pkg::ST_ADDI) begin
         add_r = {{(AW - VW){isum_ff[VW-1]}}, isum_ff};
      end else begin
         add_r = term_neg ? (~term_ext + AW'(1)) : term_ext;
      end
      add_sum = add_l + add_r;
   end

   // integrator clamp limit and final drive saturation
   always_comb begin
      lim_ext = AW'(limit_ff);
      if ($signed(drv_ff) > $signed(VMAX)) begin
         drive_sat = VMAX;
      end else if ($signed(drv_ff) < $signed(VMIN)) begin
         drive_sat = VMIN;
      end else begin
         drive_sat = drv_ff;
      end
   end

   // working register updates
   always_comb begin
      op_in          = op_ff;
      dt_in          = dt_ff;
      clr_in         = clr_ff;
      err_in         = err_ff;
      dsp_in         = dsp_ff;
      dmeas_in       = dmeas_ff;
      prev_sp_in     = prev_sp_ff;
      prev_meas_in   = prev_meas_ff;
      isum_in        = isum_ff;
      inner_in       = inner_ff;
      drv_in         = drv_ff;
      integ_in       = integ_ff;
      clamped_in     = clamped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_drive_in   = rsp_drive_ff;
      rsp_clamped_in = rsp_clamped_ff;
      case (state_ff)
         pid2dof_pkg::ST_IDLE: begin
            // take the word: form the three differences, keep inputs for next step
            if (req_fire) begin
               op_in        = pid2dof_pkg::OP_PROP;
               dt_in        = req_bus.step_time;
               clr_in       = req_bus.clear_integral;
               err_in       = {req_bus.setpoint[VW-1], req_bus.setpoint}
                            - {req_bus.measurement[VW-1], req_bus.measurement};
               dsp_in       = {req_bus.setpoint[VW-1], req_bus.setpoint}
                            - {prev_sp_ff[VW-1], prev_sp_ff};
               dmeas_in     = {req_bus.measurement[VW-1], req_bus.measurement}
                            - {prev_meas_ff[VW-1], prev_meas_ff};
               prev_sp_in   = req_bus.setpoint;
               prev_meas_in = req_bus.measurement;
               drv_in       = '0;
            end
         end
         pid2dof_pkg::ST_POST: begin
            case (op_ff)
               pid2dof_pkg::OP_PROP: begin
                  drv_in = add_sum;
                  op_in  = pid2dof_pkg::OP_SP_GAIN;
               end
               pid2dof_pkg::OP_SP_GAIN: begin
                  inner_in = term_mag;
                  op_in    = pid2dof_pkg::OP_SP_RATE;
               end
               pid2dof_pkg::OP_SP_RATE: begin
                  drv_in = add_sum;
                  op_in  = pid2dof_pkg::OP_MEAS_GAIN;
               end
               pid2dof_pkg::OP_MEAS_GAIN: begin
                  inner_in = term_mag;
                  op_in    = pid2dof_pkg::OP_MEAS_RATE;
               end
               pid2dof_pkg::OP_MEAS_RATE: begin
                  drv_in = add_sum;
                  op_in  = pid2dof_pkg::OP_INT_GAIN;
               end
               pid2dof_pkg::OP_INT_GAIN: begin
                  inner_in = term_mag;
                  op_in    = pid2dof_pkg::OP_INT_STEP;
               end
               pid2dof_pkg::OP_INT_STEP: begin
                  integ_in = add_sum;
               end
               default: begin
               end
            endcase
         end
         pid2dof_pkg::ST_CLAMP: begin
            // symmetric clamp of the integrator
            if ($signed(integ_ff) > $signed(lim_ext)) begin
               isum_in    = lim_ext[VW-1:0];
               clamped_in = 1'b1;
            end else if ($signed(integ_ff) < -$signed(lim_ext)) begin
               isum_in    = (~lim_ext[VW-1:0]) + VW'(1);
               clamped_in = 1'b1;
            end else begin
               isum_in    = integ_ff[VW-1:0];
               clamped_in = 1'b0;
            end
         end
         pid2dof_pkg::ST_ADDI: begin
            drv_in = add_sum;
         end
         pid2dof_pkg::ST_SAT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_drive_in   = drive_sat[VW-1:0];
               rsp_clamped_in = clamped_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pid2dof_pkg::ST_IDLE;
         op_ff        <= pid2dof_pkg::OP_PROP;
         rsp_valid_ff <= 1'b0;
         prev_sp_ff   <= '0;
         prev_meas_ff <= '0;
         isum_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_sp_ff   <= prev_sp_in;
         prev_meas_ff <= prev_meas_in;
         isum_ff      <= isum_in;
      end
      dt_ff          <= dt_in;
      clr_ff         <= clr_in;
      err_ff         <= err_in;
      dsp_ff         <= dsp_in;
      dmeas_ff       <= dmeas_in;
      inner_ff       <= inner_in;
      drv_ff         <= drv_in;
      integ_ff       <= integ_in;
      clamped_ff     <= clamped_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   // reciprocal of the step time
   pid2dof_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (recip_start),
      .divisor (req_bus.step_time),
      .done    (recip_done),
      .rate    (rate)
   );

   // shared digit-serial multiplier
   pid2dof_serial_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mul_ctrl),
      .a_mag    (mul_a),
      .b_mag    (mul_b),
      .done     (mul_done),
      .term_mag (term_mag)
   );

   // response word
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.drive            = rsp_drive_ff;
   assign rsp_bus.integral_clamped = rsp_clamped_ff;

endmodule

`default_nettype wire

[rtl/pid2dof_recip.sv]
// pid2dof_recip: bit-serial restoring divider giving floor(2^32 / step_time)
`timescale 1ns / 1ps
`default_nettype none

module pid2dof_recip (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pid2dof_pkg::DT_W-1:0]     divisor,
   output logic                             done,
   output logic [pid2dof_pkg::RATE_W-1:0]   rate
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [pid2dof_pkg::RECIP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [pid2dof_pkg::DT_W-1:0]          div_ff, div_in;
   logic [pid2dof_pkg::DT_W-1:0]          rem_ff, rem_in;
   logic [pid2dof_pkg::RATE_W-1:0]        quo_ff, quo_in;
   logic [pid2dof_pkg::DT_W:0]            trial;
   logic [pid2dof_pkg::DT_W:0]            diff;
   logic                                  num_bit;
   logic                                  fits;
   logic                                  last;

   // dividend 2^32 brought in msb first: a one on the first step only
   always_comb begin
      num_bit = (cnt_ff == '0);
      trial   = {rem_ff, num_bit};
      fits    = (trial >= {1'b0, div_ff});
      diff    = trial - {1'b0, div_ff};
      last    = (cnt_ff == pid2dof_pkg::RECIP_CNT_W'(pid2dof_pkg::RECIP_STEPS - 1));
   end

   // next-value logic
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[pid2dof_pkg::DT_W-1:0] : trial[pid2dof_pkg::DT_W-1:0];
         quo_in = {quo_ff[pid2dof_pkg::RATE_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // zero step time gives a zero rate
   assign done = done_ff;
   assign rate = (div_ff == '0) ? '0 : quo_ff;

endmodule

`default_nettype wire

[rtl/pid2dof_serial_mul.sv]
// pid2dof_serial_mul: digit-serial multiplier with right shift and saturation at 2^60
`timescale 1ns / 1ps
`default_nettype none

module pid2dof_serial_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  pid2dof_pkg::mul_ctrl_type          ctrl,
   input  logic [pid2dof_pkg::MUL_A_W-1:0]    a_mag,
   input  logic [pid2dof_pkg::MUL_B_W-1:0]    b_mag,
   output logic                               done,
   output logic [pid2dof_pkg::TERM_W-1:0]     term_mag
);

   localparam int DW = pid2dof_pkg::DIGIT_W;
   localparam int CW = pid2dof_pkg::DIGIT_CNT_W;

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [CW-1:0]                        cnt_ff, cnt_in;
   logic [pid2dof_pkg::SKIP_W-1:0]       skip_ff, skip_in;
   logic [pid2dof_pkg::MUL_A_W-1:0]      a_ff, a_in;
   logic [pid2dof_pkg::MUL_B_W-1:0]      b_ff, b_in;
   logic [pid2dof_pkg::MUL_B_W-1:0]      acc_ff, acc_in;
   logic [pid2dof_pkg::RES_BITS-1:0]     res_ff, res_in;
   logic                                 top_ff, top_in;
   logic                                 high_ff, high_in;
   logic [pid2dof_pkg::MUL_PART_W-1:0]   partial;
   logic [DW-1:0]                        digit;
   logic [CW-1:0]                        pos;
   logic                                 in_range;
   logic                                 last;
   logic                                 saturate;

   // one digit of a times all of b, plus the carried partial sum
   always_comb begin
      partial  = pid2dof_pkg::MUL_PART_W'(acc_ff)
               + pid2dof_pkg::MUL_PART_W'(a_ff[DW-1:0]) * pid2dof_pkg::MUL_PART_W'(b_ff);
      digit    = partial[DW-1:0];
      in_range = (cnt_ff >= CW'(skip_ff));
      pos      = cnt_ff - CW'(skip_ff);
      last     = (cnt_ff == CW'(pid2dof_pkg::MUL_DIGITS - 1));
   end

   // next-value logic: load on start, then one product digit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      skip_in = skip_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      top_in  = top_ff;
      high_in = high_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         skip_in = ctrl.skip;
         a_in    = a_mag;
         b_in    = b_mag;
         acc_in  = '0;
         res_in  = '0;
         top_in  = 1'b0;
         high_in = 1'b0;
      end else if (busy_ff) begin
         acc_in = partial[pid2dof_pkg::MUL_PART_W-1:DW];
         a_in   = a_ff >> DW;
         cnt_in = cnt_ff + 1'b1;
         // place digits of the shifted product; track anything above the limit bit
         for (int i = 0; i < pid2dof_pkg::RES_DIGITS; i++) begin
            if (in_range && (pos == CW'(i))) begin
               res_in[i*DW +: DW] = digit;
            end
         end
         if (in_range && (pos == CW'(pid2dof_pkg::RES_DIGITS))) begin
            top_in  = digit[0];
            high_in = high_ff | (|digit[DW-1:1]);
         end else if (in_range && (pos > CW'(pid2dof_pkg::RES_DIGITS))) begin
            high_in = high_ff | (|digit);
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      skip_ff <= skip_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      top_ff  <= top_in;
      high_ff <= high_in;
   end

   // magnitude above 2^60 saturates to 2^60
   always_comb begin
      saturate = high_ff | (top_ff & (|res_ff));
      term_mag = saturate ? pid2dof_pkg::TERM_LIMIT : {top_ff, res_ff};
   end

   assign done = done_ff;

endmodule

`default_nettype wire

[test/pid_two_dof_controller_test.sv]
// pid_two_dof_controller_test: self-checking regression of the two-degree-of-freedom pid controller
`timescale 1ns / 1ps

module pid_two_dof_controller_test;

   localparam int VALUE_W          = 32;
   localparam int RESET_CYCLES     = 9;
   localparam int RANDOM_PHASES    = 12;
   localparam int PHASE_WORDS      = 124;
   localparam int FULL_SCALE_PHASE = 0;
   localparam int ZERO_PHASE       = 1;
   localparam int HOLD_AT          = 200;
   localparam int HOLD_CYCLES      = 1500;
   localparam int DRAIN_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT   = 8000;

   // register indexes past the end of the list, to be ignored
   localparam logic [pid2dof_pkg::CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [pid2dof_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   localparam logic [pid2dof_pkg::DT_W-1:0]    DT_MAX    = 24'hff_ffff;
   localparam logic [pid2dof_pkg::GAIN_W-1:0]  GAIN_MAX  = 24'hff_ffff;
   localparam logic [pid2dof_pkg::LIMIT_W-1:0] LIMIT_MAX = 31'h7fff_ffff;
   localparam logic [VALUE_W-1:0]    VAL_MAX   = 32'h7fff_ffff;
   localparam logic [VALUE_W-1:0]    VAL_MIN   = 32'h8000_0000;
   localparam longint                DRIVE_MAX = 64'sh0000_0000_7fff_ffff;
   localparam longint                DRIVE_MIN = -64'sh0000_0000_8000_0000;
   localparam logic [63:0]           TERM_CAP  = 64'h1000_0000_0000_0000;

   typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_type;

   typedef struct packed {
      logic [pid2dof_pkg::DT_W-1:0] step_time;
      logic [VALUE_W-1:0]           setpoint;
      logic [VALUE_W-1:0]           measurement;
      logic                         clear_integral;
   } control_step_type;

   typedef struct packed {
      logic [VALUE_W-1:0] drive;
      logic               integral_clamped;
   } drive_word_type;

   typedef struct packed {
      row_kind_type                          kind;
      logic [pid2dof_pkg::CSR_INDEX_W-1:0]   index;
      logic [pid2dof_pkg::CSR_DATA_W-1:0]    value;
      control_step_type                      step;
      logic                                  known;
      drive_word_type                        result;
   } plan_row_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_write;
   logic [pid2dof_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pid2dof_pkg::CSR_DATA_W-1:0]  csr_wdata;

   pid2dof_req_if #(.VALUE_WIDTH(VALUE_W)) req_bus ();
   pid2dof_rsp_if #(.VALUE_WIDTH(VALUE_W)) rsp_bus ();

   pid_two_dof_controller #(.VALUE_WIDTH(VALUE_W)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // controller copy: settings, integrator and previous samples
   logic [pid2dof_pkg::GAIN_W-1:0]  prop_gain_set, int_gain_set, meas_gain_set, sp_gain_set;
   logic [pid2dof_pkg::LIMIT_W-1:0] limit_set;
   longint             integral_acc, last_setpoint, last_measurement;

   drive_word_type pending_drives [$];
   int          mismatches   = 0;
   int          drives_seen  = 0;
   int          idle_cycles  = 0;
   bit          quiet        = 1'b0;
   bit          csr_open     = 1'b0;
   bit          hold_done    = 1'b0;
   int          track_sp     = 0;
   int          track_meas   = 0;

   // exact product, right shift toward zero, magnitude capped at 2^60
   function automatic longint scaled_product(input longint a, input logic [63:0] b,
                                             input int unsigned shift);
      logic [127:0] mag;
      mag = (a < 0) ? 128'(-a) : 128'(a);
      mag = (mag * {64'd0, b}) >> shift;
      if (mag > {64'd0, TERM_CAP})
         mag = {64'd0, TERM_CAP};
      return (a < 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
   endfunction

   // drive and clamp flag for one step word, advancing the controller copy
   function automatic drive_word_type predict_drive(input control_step_type w);
      logic [63:0] rate;
      longint      sp, meas, err, p, ds, dm, inc, sum, total;
      drive_word_type r;
      sp   = longint'($signed(w.setpoint));
      meas = longint'($signed(w.measurement));
      rate = (w.step_time != '0) ? (64'h1_0000_0000 / 64'(w.step_time)) : 64'd0;
      err  = sp - meas;
      p    = scaled_product(err, 64'(prop_gain_set), 16);
      ds   = scaled_product(scaled_product(sp - last_setpoint, 64'(sp_gain_set), 0), rate, 24);
      dm   = scaled_product(scaled_product(meas - last_measurement, 64'(meas_gain_set), 0),
                            rate, 24);
      inc  = scaled_product(scaled_product(err, 64'(int_gain_set), 0),
                            64'(w.step_time), 40);
      // integrator: optional clear, accumulate, symmetric clamp
      sum = (w.clear_integral ? longint'(0) : integral_acc) + inc;
      r.integral_clamped = 1'b0;
      if (sum > longint'(limit_set)) begin
         sum = longint'(limit_set);
         r.integral_clamped = 1'b1;
      end else if (sum < -longint'(limit_set)) begin
         sum = -longint'(limit_set);
         r.integral_clamped = 1'b1;
      end
      integral_acc = sum;
      total = p + (ds - dm) + sum;
      if (total > DRIVE_MAX)
         total = DRIVE_MAX;
      else if (total < DRIVE_MIN)
         total = DRIVE_MIN;
      r.drive = total[VALUE_W-1:0];
      last_setpoint    = sp;
      last_measurement = meas;
      return r;
   endfunction

   function automatic plan_row_type reg_row(input logic [pid2dof_pkg::CSR_INDEX_W-1:0] index,
                                            input logic [pid2dof_pkg::CSR_DATA_W-1:0] value);
      plan_row_type r;
      r       = '0;
      r.kind  = ROW_WRITE;
      r.index = index;
      r.value = value;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic [pid2dof_pkg::DT_W-1:0] dt,
                                              input logic [VALUE_W-1:0] sp,
                                              input logic [VALUE_W-1:0] meas,
                                              input logic clr,
                                              input logic [VALUE_W-1:0] drive,
                                              input logic clamped);
      plan_row_type r;
      r        = '0;
      r.kind   = ROW_STEP;
      r.step   = '{dt, sp, meas, clr};
      r.known  = 1'b1;
      r.result = '{drive, clamped};
      return r;
   endfunction

   function automatic plan_row_type step_row(input logic [pid2dof_pkg::DT_W-1:0] dt,
                                             input logic [VALUE_W-1:0] sp,
                                             input logic [VALUE_W-1:0] meas,
                                             input logic clr);
      plan_row_type r;
      r       = known_row(dt, sp, meas, clr, '0, 1'b0);
      r.known = 1'b0;
      return r;
   endfunction

   // gain setting with junk above bit 23, extremes in the first two phases
   function automatic logic [pid2dof_pkg::CSR_DATA_W-1:0] pick_gain(input int unsigned phase);
      logic [pid2dof_pkg::GAIN_W-1:0] g;
      case (phase)
         FULL_SCALE_PHASE: g = GAIN_MAX;
         ZERO_PHASE:       g = '0;
         default:
            case ($urandom_range(0, 4))
               0:       g = '0;
               1:       g = GAIN_MAX;
               2:       g = pid2dof_pkg::GAIN_W'($urandom);
               default: g = pid2dof_pkg::GAIN_W'($urandom_range(0, 24'h03_ffff));
            endcase
      endcase
      return {7'($urandom), g};
   endfunction

   // register write, only once the controller has gone quiet
   task automatic write_reg(input logic [pid2dof_pkg::CSR_INDEX_W-1:0] index,
                            input logic [pid2dof_pkg::CSR_DATA_W-1:0] value);
      if (!csr_open) begin
         req_bus.valid <= 1'b0;
         while (pending_drives.size() != 0)
            @(posedge clock);
         csr_open = 1'b1;
      end
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         pid2dof_pkg::CSR_PROP_GAIN:      prop_gain_set = value[pid2dof_pkg::GAIN_W-1:0];
         pid2dof_pkg::CSR_INT_GAIN:       int_gain_set  = value[pid2dof_pkg::GAIN_W-1:0];
         pid2dof_pkg::CSR_MEAS_GAIN:      meas_gain_set = value[pid2dof_pkg::GAIN_W-1:0];
         pid2dof_pkg::CSR_SP_GAIN:        sp_gain_set   = value[pid2dof_pkg::GAIN_W-1:0];
         pid2dof_pkg::CSR_INTEGRAL_LIMIT: limit_set     = value[pid2dof_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // offer one step word, queue its drive once taken, then maybe idle
   task automatic offer_step(input control_step_type w, input logic known,
                             input drive_word_type typed);
      drive_word_type predicted;
      if (csr_open) begin
         csr_write <= 1'b0;
         csr_open = 1'b0;
      end
      req_bus.valid          <= 1'b1;
      req_bus.step_time      <= w.step_time;
      req_bus.setpoint       <= w.setpoint;
      req_bus.measurement    <= w.measurement;
      req_bus.clear_integral <= w.clear_integral;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      predicted = predict_drive(w);
      pending_drives.push_back(known ? typed : predicted);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // stimulus: reset, directed table, then random phases
   initial begin
      plan_row_type     plan [$];
      control_step_type w;
      reset                  <= 1'b1;
      csr_write              <= 1'b0;
      csr_index              <= '0;
      csr_wdata              <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.step_time      <= '0;
      req_bus.setpoint       <= '0;
      req_bus.measurement    <= '0;
      req_bus.clear_integral <= 1'b0;
      prop_gain_set    = '0;
      int_gain_set     = '0;
      meas_gain_set    = '0;
      sp_gain_set      = '0;
      limit_set        = '0;
      integral_acc     = 0;
      last_setpoint    = 0;
      last_measurement = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      plan = '{
         // zero gains after reset: drive stays at zero
         known_row('0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0),
         known_row(DT_MAX, VAL_MAX, VAL_MIN, 1'b1, 32'h0, 1'b0),
         known_row(24'd1, VAL_MIN, VAL_MAX, 1'b0, 32'h0, 1'b0),
         // unity proportional gain with junk above bit 23; spare indexes ignored
         reg_row(pid2dof_pkg::CSR_PROP_GAIN, 31'h7f01_0000),
         reg_row(CSR_SPARE_FIRST, 31'h7fff_ffff),
         reg_row(CSR_SPARE_LAST, 31'h5555_5555),
         known_row('0, 32'h0005_0000, 32'h0002_0000, 1'b0, 32'h0003_0000, 1'b0),
         known_row('0, VAL_MAX, VAL_MIN, 1'b0, VAL_MAX, 1'b0),
         known_row('0, VAL_MIN, VAL_MAX, 1'b0, VAL_MIN, 1'b0),
         known_row('0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0),
         // integrator alone at full gain, widest limit: clamps both ways, clear empties it
         reg_row(pid2dof_pkg::CSR_PROP_GAIN, 31'h0),
         reg_row(pid2dof_pkg::CSR_INT_GAIN, 31'h7fff_ffff),
         reg_row(pid2dof_pkg::CSR_INTEGRAL_LIMIT, LIMIT_MAX),
         known_row(DT_MAX, VAL_MAX, VAL_MIN, 1'b0, VAL_MAX, 1'b1),
         known_row(DT_MAX, VAL_MIN, VAL_MAX, 1'b1, 32'h8000_0001, 1'b1),
         known_row('0, 32'h0, 32'h0, 1'b0, 32'h8000_0001, 1'b0),
         known_row('0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0),
         // every gain at full scale; at the shortest step the derivative terms saturate
         reg_row(pid2dof_pkg::CSR_PROP_GAIN, {7'h7f, GAIN_MAX}),
         reg_row(pid2dof_pkg::CSR_MEAS_GAIN, {7'h00, GAIN_MAX}),
         reg_row(pid2dof_pkg::CSR_SP_GAIN, {7'h2a, GAIN_MAX}),
         reg_row(pid2dof_pkg::CSR_INTEGRAL_LIMIT, 31'h0001_0000),
         step_row(24'd1, VAL_MAX, 32'h0, 1'b0),
         step_row(24'd1, VAL_MAX, VAL_MAX, 1'b0),
         step_row(DT_MAX, VAL_MIN, VAL_MIN, 1'b0),
         step_row(24'h00_0100, 32'h0001_0000, 32'hffff_8000, 1'b1),
         step_row('0, 32'h7fff_0000, 32'h0000_0001, 1'b0),
         // moderate gains, integrator limit at zero
         reg_row(pid2dof_pkg::CSR_PROP_GAIN, 31'h0000_8000),
         reg_row(pid2dof_pkg::CSR_INT_GAIN, 31'h0002_0000),
         reg_row(pid2dof_pkg::CSR_MEAS_GAIN, 31'h0000_0100),
         reg_row(pid2dof_pkg::CSR_SP_GAIN, 31'h0000_0080),
         reg_row(pid2dof_pkg::CSR_INTEGRAL_LIMIT, 31'h0),
         step_row(24'h00_4000, 32'h0001_0000, 32'h0, 1'b0),
         step_row(24'h00_4000, 32'h0001_8000, 32'h0000_8000, 1'b0),
         step_row(24'h80_0000, 32'hfff0_0000, 32'h0010_0000, 1'b1),
         step_row(24'd1, 32'h0, 32'h0, 1'b0),
         step_row(DT_MAX, 32'h1234_5678, 32'hedcb_a987, 1'b0)
      };
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE)
            write_reg(plan[i].index, plan[i].value);
         else
            offer_step(plan[i].step, plan[i].known, plan[i].result);
      end

      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         quiet = (phase == RANDOM_PHASES - 1);
         // fresh settings for the phase, sometimes a stray spare write
         write_reg(pid2dof_pkg::CSR_PROP_GAIN, pick_gain(phase));
         write_reg(pid2dof_pkg::CSR_INT_GAIN, pick_gain(phase));
         write_reg(pid2dof_pkg::CSR_MEAS_GAIN, pick_gain(phase));
         write_reg(pid2dof_pkg::CSR_SP_GAIN, pick_gain(phase));
         write_reg(pid2dof_pkg::CSR_INTEGRAL_LIMIT,
                   (phase == FULL_SCALE_PHASE) ? LIMIT_MAX :
                   (phase == ZERO_PHASE) ? 31'h0 :
                   ($urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 32'h00ff_ffff))));
         if ($urandom_range(0, 1))
            write_reg(pid2dof_pkg::CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST,
                                                               CSR_SPARE_LAST)),
                      pid2dof_pkg::CSR_DATA_W'($urandom));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 7) == 0) begin
               // noise word: any value in any field
               case ($urandom_range(0, 3))
                  0:       w.step_time = '0;
                  1:       w.step_time = 24'd1;
                  2:       w.step_time = DT_MAX;
                  default: w.step_time = pid2dof_pkg::DT_W'($urandom);
               endcase
               w.setpoint       = $urandom;
               w.measurement    = $urandom;
               w.clear_integral = 1'($urandom);
            end else begin
               // control loop word: setpoint steps now and then, measurement follows it
               if ($urandom_range(0, 11) == 0)
                  track_sp = int'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
               track_meas = track_meas + (track_sp - track_meas) / 8
                            + int'($urandom_range(0, 32'h0fff)) - 32'sh0800;
               w.step_time      = pid2dof_pkg::DT_W'($urandom_range(24'h00_0400, 24'h00_8000));
               w.setpoint       = track_sp;
               w.measurement    = track_meas;
               w.clear_integral = ($urandom_range(0, 31) == 0);
            end
            offer_step(w, 1'b0, '0);
         end
      end

      // drain and close
      req_bus.valid <= 1'b0;
      while (pending_drives.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("pid_two_dof_controller regression: pass");
      else
         $display("pid_two_dof_controller regression: fail");
      $finish;
   end

   // result side: random stalls, one long hold-off, check against the oldest drive
   initial begin
      int             stall_left;
      drive_word_type want;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_drives.size() == 0) begin
               $error("drive: expected no word, got %0d", rsp_bus.drive);
               mismatches++;
            end else begin
               want = pending_drives.pop_front();
               if (rsp_bus.drive !== want.drive) begin
                  $error("drive: expected %0d, got %0d", $signed(want.drive), rsp_bus.drive);
                  mismatches++;
               end
               if (rsp_bus.integral_clamped !== want.integral_clamped) begin
                  $error("integral_clamped: expected %0d, got %0d",
                         want.integral_clamped, rsp_bus.integral_clamped);
                  mismatches++;
               end
            end
            drives_seen++;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            if (!hold_done && drives_seen == HOLD_AT) begin
               stall_left = HOLD_CYCLES;
               hold_done  = 1'b1;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 11) == 0) begin
               stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
               rsp_bus.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("pid_two_dof_controller regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
